FILE: rtl/core/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Shared widths, defaults, register indexes and the ease table generator for
// the servo motion interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package smi_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF       = 8;
    localparam int FRAC_BITS_DEF      = 8;
    localparam int DEG_LOW_DEF        = 0;
    localparam int DEG_HIGH_DEF       = 180;
    localparam int MID_PULSE_DEF      = 1500;
    localparam int COS_TABLE_BITS_DEF = 6;

    // Field widths
    localparam int CH_W     = 3;
    localparam int DEG_W    = 10;
    localparam int SPEED_W  = 16;
    localparam int PULSE_W  = 16;
    localparam int TIME_W   = 17;
    localparam int EASE_W   = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Datapath widths: the magnitude of the mapping numerator stays below 2^27
    localparam int DOFF_W = DEG_W + 1;
    localparam int MAG_W  = 27;
    localparam int MUL_W  = 29;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

    // Interpolation modes
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_COSINE = 1'b1;

    // Per-channel state entry
    typedef struct packed {
        logic                 active;
        logic [SPEED_W-1:0]   speed;
        logic [TIME_W-1:0]    mtime;
        logic [PULSE_W-1:0]   to_pulse;
        logic [PULSE_W-1:0]   from_pulse;
    } chan_state_t;

    localparam logic [63:0] Q30    = 64'd1 << 30;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Ease weight on the start pulse, (1 + cos(pi*k/N)) / 2 in Q16, N = 2^tb.
    // Sine from its Taylor series to x^11 in Q30, Horner form.
    function automatic logic [EASE_W-1:0] ease_entry(input int unsigned k,
                                                     input int unsigned tb);
        logic [63:0] v;
        logic [63:0] half;
        logic [63:0] d;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] q;
        logic        below;
        v     = (64'(k) << 30) >> tb;
        half  = Q30 >> 1;
        below = (v < half);
        d     = below ? (half - v) : (v - half);
        x     = (d * PI_Q30) >> 30;
        x2    = (x * x) >> 30;
        r     = Q30;
        r     = Q30 - ((x2 * r) >> 30) / 64'd110;
        r     = Q30 - ((x2 * r) >> 30) / 64'd72;
        r     = Q30 - ((x2 * r) >> 30) / 64'd42;
        r     = Q30 - ((x2 * r) >> 30) / 64'd20;
        r     = Q30 - ((x2 * r) >> 30) / 64'd6;
        s     = (x * r) >> 30;
        if (s > Q30) begin
            s = Q30;
        end
        e = below ? ((Q30 + s) >> 1) : ((Q30 - s) >> 1);
        q = (e + (64'd1 << 13)) >> 14;
        if (q > 64'd65536) begin
            q = 64'd65536;
        end
        return q[EASE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/servo_motion_interpolator_core.sv
// ----------------------------------------------------------------------------
// servo_motion_interpolator_core
// Multi-channel servo move interpolator: per-channel state in one synchronous
// memory, updated by read-modify-write through one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  ----------------------------------
//  s_       in         s_tvalid/s_tready  tuser command, tdata ch/deg/speed
//  m_       out        m_tvalid/m_tready  tdata out_channel/pulse_width/moving
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
//  One item is in work at a time, paced by the shared multiplier. A tick with
//  a channel out of range, or any item for such a channel, is dropped in its
//  acceptance cycle. The result sits in an output register, so a stalled m_
//  side holds the block only when the next tick result is ready. Reset is
//  synchronous, active low; per-channel state reads as its reset value until
//  first written, through one valid flag per channel.
//
`default_nettype none

module servo_motion_interpolator_core
    import smi_pkg::*;
#(
    parameter int CHANNELS       = CHANNELS_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int DEG_LOW        = DEG_LOW_DEF,
    parameter int DEG_HIGH       = DEG_HIGH_DEF,
    parameter int MID_PULSE      = MID_PULSE_DEF,
    parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // channel[2:0], angle[12:3],
                                                 // speed[28:13], zero fill
    input  wire logic                 s_tuser,   // command

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // out_channel[2:0], pulse_width[18:3],
                                                 // moving[19], zero fill

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_SPAN  = 1 << CH_W;
    localparam int ONE      = 1 << FRAC_BITS;
    localparam int RANGE    = (DEG_HIGH - DEG_LOW < 1) ? 1 : (DEG_HIGH - DEG_LOW);
    localparam longint unsigned RECIP = (longint'(1) << MAG_W) / RANGE;
    localparam int EASE_LEN = (1 << COS_TABLE_BITS) + 1;
    localparam int IDX_W    = COS_TABLE_BITS + 1;
    localparam int TSH_W    = TIME_W + COS_TABLE_BITS;

    localparam logic [PULSE_W-1:0] MID = PULSE_W'(MID_PULSE);
    localparam chan_state_t RESET_ENTRY = '{
        active:     1'b1,
        speed:      '0,
        mtime:      '0,
        to_pulse:   MID,
        from_pulse: MID
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV_DIFF,
        S_MV_BASE,
        S_MV_ABS,
        S_MV_RECIP,
        S_MV_QMUL,
        S_MV_QFIX,
        S_MV_SIGN,
        S_MV_SCALE,
        S_MV_WRITE,
        S_TK_TIME,
        S_TK_EASE,
        S_TK_MUL0,
        S_TK_MUL1,
        S_TK_OUT
    } state_t;

    // Configuration registers
    logic [PULSE_W-1:0]       cfg_min_reg;
    logic [PULSE_W-1:0]       cfg_max_reg;
    logic [CFG_W-1:0]         cfg_amp_reg;
    logic signed [CFG_W-1:0]  cfg_bias_reg;
    logic                     cfg_mode_reg;

    // Control
    state_t                   state_reg;
    state_t                   state_next;
    logic [CHANNELS-1:0]      valid_reg;
    logic                     m_tvalid_reg;
    logic [23:0]              m_tdata_reg;

    // Memory and its read port
    chan_state_t              state_mem [CHANNELS];
    chan_state_t              rd_data_reg;
    logic                     rd_valid_reg;
    chan_state_t              cur;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     mem_we;
    chan_state_t              mem_wdata;

    // Item fields
    logic [CH_W-1:0]          s_ch;
    logic                     in_range;
    logic [CH_W-1:0]          ch_reg;
    logic signed [DEG_W-1:0]  deg_reg;
    logic [SPEED_W-1:0]       spd_reg;

    // Datapath
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] acc_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         q_reg;
    logic signed [PROD_W-1:0] rem;
    logic signed [DOFF_W-1:0] deg_off;
    logic signed [PULSE_W:0]  pulse_diff;
    logic signed [PROD_W-1:0] tot_sh;
    logic [PULSE_W-1:0]       sat_pulse;
    logic [TIME_W:0]          time_sum;
    logic [TIME_W-1:0]        t_reg;
    logic                     act_reg;
    logic [TSH_W-1:0]         t_sh;
    logic [IDX_W-1:0]         ease_idx;
    logic [EASE_W-1:0]        ease_rom [EASE_LEN];
    logic [EASE_W-1:0]        ease_reg;
    logic [PULSE_W-1:0]       pulse_out;
    logic                     out_free;

    // Ease table, fixed at elaboration
    for (genvar k = 0; k < EASE_LEN; k++) begin : g_ease
        assign ease_rom[k] = ease_entry(k, COS_TABLE_BITS);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign s_ch     = s_tdata[CH_W-1:0];
    assign in_range = (CHANNELS >= CH_SPAN) || (s_ch < CH_W'(CHANNELS));
    assign rd_addr  = ADDR_W'(s_ch);
    assign wr_addr  = ADDR_W'(ch_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cur      = rd_valid_reg ? rd_data_reg : RESET_ENTRY;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_min_reg  <= 16'd1000;
            cfg_max_reg  <= 16'd2000;
            cfg_amp_reg  <= 16'd256;
            cfg_bias_reg <= '0;
            cfg_mode_reg <= MODE_LINEAR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_PULSE:   cfg_min_reg  <= cfg_wdata;
                REG_MAX_PULSE:   cfg_max_reg  <= cfg_wdata;
                REG_AMPLITUDE:   cfg_amp_reg  <= cfg_wdata;
                REG_BIAS:        cfg_bias_reg <= $signed(cfg_wdata);
                REG_INTERP_MODE: cfg_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channel state memory: read while idle, written at the end of an item
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            rd_data_reg  <= state_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (mem_we) begin
            state_mem[wr_addr] <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand selection
    // ------------------------------------------------------------------
    assign deg_off    = DOFF_W'(deg_reg) - DOFF_W'(DEG_LOW);
    assign pulse_diff = $signed({1'b0, cfg_max_reg}) - $signed({1'b0, cfg_min_reg});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MV_DIFF: begin
                mul_a = MUL_W'(deg_off);
                mul_b = MUL_W'(pulse_diff);
            end
            S_MV_BASE: begin
                mul_a = MUL_W'(cfg_min_reg);
                mul_b = MUL_W'(RANGE);
            end
            S_MV_RECIP: begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(RECIP);
            end
            S_MV_QMUL: begin
                mul_a = MUL_W'(q_reg);
                mul_b = MUL_W'(RANGE);
            end
            S_MV_SCALE: begin
                mul_a = acc_reg[MUL_W-1:0];
                mul_b = MUL_W'(cfg_amp_reg);
            end
            S_TK_MUL0: begin
                mul_a = MUL_W'(cur.from_pulse);
                mul_b = (cfg_mode_reg == MODE_COSINE) ? MUL_W'(ease_reg)
                                                      : MUL_W'(TIME_W'(ONE) - t_reg);
            end
            S_TK_MUL1: begin
                mul_a = MUL_W'(cur.to_pulse);
                mul_b = (cfg_mode_reg == MODE_COSINE) ? MUL_W'(EASE_W'(65536) - ease_reg)
                                                      : MUL_W'(t_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Remainder check after the reciprocal estimate, which is at most one low
    assign rem = $signed(PROD_W'(mag_reg)) - acc_reg;

    // Truncate toward zero, then clamp; a negative total clamps to zero
    assign tot_sh    = acc_reg >>> FRAC_BITS;
    assign sat_pulse = acc_reg[PROD_W-1]          ? '0 :
                       (|tot_sh[PROD_W-1:PULSE_W]) ? '1 : tot_sh[PULSE_W-1:0];

    assign time_sum = {1'b0, cur.mtime} + (TIME_W + 1)'(cur.speed);

    assign t_sh     = {t_reg, {COS_TABLE_BITS{1'b0}}} >> FRAC_BITS;
    assign ease_idx = (t_sh > TSH_W'(EASE_LEN - 1)) ? IDX_W'(EASE_LEN - 1)
                                                   : t_sh[IDX_W-1:0];

    assign pulse_out = (cfg_mode_reg == MODE_COSINE) ? acc_reg[16 +: PULSE_W]
                                                     : acc_reg[FRAC_BITS +: PULSE_W];

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                ch_reg  <= s_ch;
                deg_reg <= $signed(s_tdata[CH_W +: DEG_W]);
                spd_reg <= s_tdata[CH_W + DEG_W +: SPEED_W];
            end
            S_MV_DIFF:  acc_reg <= mul_p;
            S_MV_BASE:  acc_reg <= acc_reg + mul_p;
            S_MV_ABS: begin
                neg_reg <= acc_reg[PROD_W-1];
                mag_reg <= acc_reg[PROD_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
            end
            S_MV_RECIP: q_reg   <= mul_p[MAG_W +: MAG_W];
            S_MV_QMUL:  acc_reg <= mul_p;
            S_MV_QFIX: begin
                if (rem >= $signed(PROD_W'(RANGE))) begin
                    q_reg <= q_reg + 1'b1;
                end
            end
            S_MV_SIGN: begin
                acc_reg <= neg_reg ? -$signed(PROD_W'(q_reg)) : $signed(PROD_W'(q_reg));
            end
            S_MV_SCALE: begin
                acc_reg <= mul_p + ($signed(PROD_W'(cfg_bias_reg)) <<< FRAC_BITS);
            end
            S_TK_TIME: begin
                // Hold at one once reached; the tick after that ends the move
                if (cur.mtime >= TIME_W'(ONE)) begin
                    t_reg   <= TIME_W'(ONE);
                    act_reg <= 1'b0;
                end else begin
                    t_reg   <= (time_sum > (TIME_W + 1)'(ONE)) ? TIME_W'(ONE)
                                                               : time_sum[TIME_W-1:0];
                    act_reg <= 1'b1;
                end
            end
            S_TK_EASE:  ease_reg <= ease_rom[ease_idx];
            S_TK_MUL0:  acc_reg  <= mul_p;
            S_TK_MUL1:  acc_reg  <= acc_reg + mul_p;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_wdata  = cur;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && in_range) begin
                    state_next = s_tuser ? S_TK_TIME : S_MV_DIFF;
                end
            end
            S_MV_DIFF:  state_next = S_MV_BASE;
            S_MV_BASE:  state_next = S_MV_ABS;
            S_MV_ABS:   state_next = S_MV_RECIP;
            S_MV_RECIP: state_next = S_MV_QMUL;
            S_MV_QMUL:  state_next = S_MV_QFIX;
            S_MV_QFIX:  state_next = S_MV_SIGN;
            S_MV_SIGN:  state_next = S_MV_SCALE;
            S_MV_SCALE: state_next = S_MV_WRITE;
            S_MV_WRITE: begin
                mem_we               = 1'b1;
                mem_wdata.from_pulse = cur.to_pulse;
                mem_wdata.to_pulse   = sat_pulse;
                mem_wdata.mtime      = '0;
                mem_wdata.speed      = spd_reg;
                state_next           = S_IDLE;
            end
            S_TK_TIME:  state_next = S_TK_EASE;
            S_TK_EASE:  state_next = S_TK_MUL0;
            S_TK_MUL0:  state_next = S_TK_MUL1;
            S_TK_MUL1:  state_next = S_TK_OUT;
            S_TK_OUT: begin
                if (out_free) begin
                    mem_we           = 1'b1;
                    mem_wdata.mtime  = t_reg;
                    mem_wdata.active = act_reg;
                    state_next       = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == S_TK_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {4'b0, act_reg, pulse_out, ch_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
